@@ src/bhipc_pkg.sv @@
// Package for the button hold and idle power control block.
// Holds the request, result and register types, event and power codes, and
// register indexes. No dependencies.
`default_nettype none

package bhipc_pkg;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_IDLE_TIMEOUT   = 3'd0;
   localparam logic [2:0] REG_SETTINGS_HOLD  = 3'd1;
   localparam logic [2:0] REG_RESUME_HOLD    = 3'd2;
   localparam logic [2:0] REG_POWER_HOLD     = 3'd3;
   localparam logic [2:0] REG_SHORT_PRESS    = 3'd4;
   localparam logic [2:0] REG_EDGE_LOCKOUT   = 3'd5;
   localparam logic [2:0] REG_LOW_BATT_PCT   = 3'd6;
   localparam logic [2:0] REG_BATT_PERIOD    = 3'd7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 27;

   // Reset values of the registers
   localparam logic [26:0] IDLE_TIMEOUT_RST  = 27'd300000;
   localparam logic [15:0] SETTINGS_HOLD_RST = 16'd5000;
   localparam logic [15:0] RESUME_HOLD_RST   = 16'd900;
   localparam logic [15:0] POWER_HOLD_RST    = 16'd2000;
   localparam logic [15:0] SHORT_PRESS_RST   = 16'd40;
   localparam logic [15:0] EDGE_LOCKOUT_RST  = 16'd30;
   localparam logic [6:0]  LOW_BATT_PCT_RST  = 7'd3;
   localparam logic [21:0] BATT_PERIOD_RST   = 22'd60000;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 8;

   // Power-off codes
   localparam logic [1:0] PWR_ON       = 2'd0;
   localparam logic [1:0] PWR_OFF      = 2'd1;
   localparam logic [1:0] PWR_LOW_BATT = 2'd2;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_UP       = 3'd1,
      EV_DOWN     = 3'd2,
      EV_SETTINGS = 3'd3,
      EV_RESUME   = 3'd4
   } side_event_type;

   typedef struct packed {
      logic [26:0] idle_timeout_ms;
      logic [15:0] up_hold_time;
      logic [15:0] down_hold_time;
      logic [15:0] power_hold_ms;
      logic [15:0] short_press_min_ms;
      logic [15:0] edge_lockout_ms;
      logic [6:0]  batt_low_level;
      logic [21:0] battery_check_period_ms;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        up_down;
      logic        down_down;
      logic        ok_down;
      logic        at_home;
      logic        pinned_mode;
      logic        app_wants_tick;
      logic        user_touch;
      logic        app_accepts_ok;
      logic        charging;
      logic        battery_present;
      logic [6:0]  battery_pct;
   } req_type;

   typedef struct packed {
      side_event_type side_event;
      logic           ok_short;
      logic [1:0]     power_off;
      logic           activity;
   } rsp_type;

endpackage

`default_nettype wire

@@ src/button_hold_and_idle_power_control.sv @@
// Top level of the button hold and idle power control block.
// Depends on bhipc_pkg, bhipc_csr and bhipc_core.
//
//   port group  direction  handshake              contents
//   req_*       in         tvalid/tready          one poll tick (56-bit tdata)
//   rsp_*       out        tvalid/tready          one decision per tick (8-bit tdata)
//   csr_*       in         csr_wr_en, no wait     register index and write data
//
// Each request passes through the input register, then through the decision
// logic into the result register. One request is accepted per cycle while
// the result is not stalled; the tracking state updates as a request
// moves into the result register, so the next one sees it directly.
// Reset (synchronous) empties both registers and restores all registers and
// state. A stalled result holds both stages; the input stage fills while it
// is empty or while its request moves on into the result register.
`default_nettype none

module button_hold_and_idle_power_control (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // [31:0] now_ms, [32] up_down, [33] down_down, [34] ok_down, [35] at_home,
   // [36] pinned_mode, [37] app_wants_tick, [38] user_touch, [39] app_accepts_ok,
   // [40] charging, [41] battery_present, [48:42] battery_pct, [55:49] zero
   input  wire logic [bhipc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // [2:0] side_event, [3] ok_short, [5:4] power_off, [6] activity, [7] zero
   output      logic [bhipc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_wr_en,
   input  wire logic [bhipc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bhipc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bhipc_pkg::*;

   cfg_type cfg;
   req_type req_unpacked;
   req_type req_ff;
   rsp_type rsp_next;
   logic    req_valid_ff;
   logic    rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic    advance;

   // Unpack the request fields from tdata
   assign req_unpacked.now_ms          = req_tdata[31:0];
   assign req_unpacked.up_down         = req_tdata[32];
   assign req_unpacked.down_down       = req_tdata[33];
   assign req_unpacked.ok_down         = req_tdata[34];
   assign req_unpacked.at_home         = req_tdata[35];
   assign req_unpacked.pinned_mode     = req_tdata[36];
   assign req_unpacked.app_wants_tick  = req_tdata[37];
   assign req_unpacked.user_touch      = req_tdata[38];
   assign req_unpacked.app_accepts_ok  = req_tdata[39];
   assign req_unpacked.charging        = req_tdata[40];
   assign req_unpacked.battery_present = req_tdata[41];
   assign req_unpacked.battery_pct     = req_tdata[48:42];

   // Move the held request into the result register when that slot frees up
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   bhipc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bhipc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .cfg     (cfg),
      .req     (req_ff),
      .rsp     (rsp_next)
   );

   // Input register: load on every accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff <= req_unpacked;
      end
   end

   // Result register: hold while the consumer stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {1'b0, rsp_next.activity, rsp_next.power_off,
                         rsp_next.ok_short, rsp_next.side_event};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ src/bhipc_csr.sv @@
// Configuration register file of the button hold and idle power control block.
// Depends on bhipc_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module bhipc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [bhipc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bhipc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output bhipc_pkg::cfg_type                      cfg
);
   import bhipc_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_timeout_ms         <= IDLE_TIMEOUT_RST;
         cfg_ff.up_hold_time            <= SETTINGS_HOLD_RST;
         cfg_ff.down_hold_time          <= RESUME_HOLD_RST;
         cfg_ff.power_hold_ms           <= POWER_HOLD_RST;
         cfg_ff.short_press_min_ms      <= SHORT_PRESS_RST;
         cfg_ff.edge_lockout_ms         <= EDGE_LOCKOUT_RST;
         cfg_ff.batt_low_level          <= LOW_BATT_PCT_RST;
         cfg_ff.battery_check_period_ms <= BATT_PERIOD_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_IDLE_TIMEOUT:  cfg_ff.idle_timeout_ms         <= csr_wdata[26:0];
            REG_SETTINGS_HOLD: cfg_ff.up_hold_time            <= csr_wdata[15:0];
            REG_RESUME_HOLD:   cfg_ff.down_hold_time          <= csr_wdata[15:0];
            REG_POWER_HOLD:    cfg_ff.power_hold_ms           <= csr_wdata[15:0];
            REG_SHORT_PRESS:   cfg_ff.short_press_min_ms      <= csr_wdata[15:0];
            REG_EDGE_LOCKOUT:  cfg_ff.edge_lockout_ms         <= csr_wdata[15:0];
            REG_LOW_BATT_PCT:  cfg_ff.batt_low_level          <= csr_wdata[6:0];
            REG_BATT_PERIOD:   cfg_ff.battery_check_period_ms <= csr_wdata[21:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ src/bhipc_core.sv @@
// Per-tick decision logic and tracking state of the button and power control.
// Depends on bhipc_pkg for cfg_type, req_type, rsp_type and the codes.
`default_nettype none

module bhipc_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step_en,
   input  bhipc_pkg::cfg_type cfg,
   input  bhipc_pkg::req_type req,
   output bhipc_pkg::rsp_type rsp
);
   import bhipc_pkg::*;

   logic        up_prev_ff, up_prev_in;
   logic        down_prev_ff, down_prev_in;
   logic        hold_fired_ff, hold_fired_in;
   logic        ok_held_ff, ok_held_in;
   logic [31:0] up_press_time_ff, up_press_time_in;
   logic [31:0] down_press_time_ff, down_press_time_in;
   logic [31:0] last_edge_time_ff, last_edge_time_in;
   logic [31:0] ok_press_time_ff, ok_press_time_in;
   logic [31:0] last_activity_time_ff, last_activity_time_in;
   logic [31:0] last_batt_time_ff, last_batt_time_in;
   logic [1:0]  off_latched_ff, off_latched_in;

   logic        up_edge, down_edge;
   logic [31:0] up_press_eff, down_press_eff, ok_press_eff;
   logic [31:0] up_elapsed, down_elapsed, edge_elapsed, ok_elapsed;
   logic [31:0] batt_elapsed;

   assign up_edge   = req.up_down && !up_prev_ff;
   assign down_edge = req.down_down && !down_prev_ff;

   // A fresh press starts its hold timer in this very tick
   assign up_press_eff   = up_edge   ? req.now_ms : up_press_time_ff;
   assign down_press_eff = down_edge ? req.now_ms : down_press_time_ff;
   assign ok_press_eff   = ok_held_ff ? ok_press_time_ff : req.now_ms;

   assign up_elapsed   = req.now_ms - up_press_eff;
   assign down_elapsed = req.now_ms - down_press_eff;
   assign edge_elapsed = req.now_ms - last_edge_time_ff;
   assign ok_elapsed   = req.now_ms - ok_press_eff;
   assign batt_elapsed = req.now_ms - last_batt_time_ff;

   always_comb begin
      logic [1:0]  off;
      logic [31:0] idle_gap;
      up_prev_in            = up_prev_ff;
      down_prev_in          = down_prev_ff;
      hold_fired_in         = hold_fired_ff;
      ok_held_in            = ok_held_ff;
      up_press_time_in      = up_press_time_ff;
      down_press_time_in    = down_press_time_ff;
      last_edge_time_in     = last_edge_time_ff;
      ok_press_time_in      = ok_press_time_ff;
      last_activity_time_in = last_activity_time_ff;
      last_batt_time_in     = last_batt_time_ff;
      off                   = off_latched_ff;
      idle_gap              = '0;
      rsp.side_event        = EV_NONE;
      rsp.ok_short          = 1'b0;
      rsp.activity          = 1'b0;

      if (off_latched_ff == PWR_ON) begin
         if (req.user_touch) begin
            last_activity_time_in = req.now_ms;
            rsp.activity          = 1'b1;
         end

         if (!req.pinned_mode) begin
            up_prev_in   = req.up_down;
            down_prev_in = req.down_down;
            if (req.at_home) begin
               up_press_time_in   = up_press_eff;
               down_press_time_in = down_press_eff;
               if (!req.up_down && !req.down_down) begin
                  hold_fired_in = 1'b0;
               end else if (!hold_fired_ff) begin
                  if (req.up_down && up_elapsed >= {16'd0, cfg.up_hold_time}) begin
                     hold_fired_in         = 1'b1;
                     last_activity_time_in = req.now_ms;
                     rsp.activity          = 1'b1;
                     rsp.side_event        = EV_SETTINGS;
                  end else if (req.down_down &&
                               down_elapsed >= {16'd0, cfg.down_hold_time}) begin
                     hold_fired_in         = 1'b1;
                     last_activity_time_in = req.now_ms;
                     rsp.activity          = 1'b1;
                     rsp.side_event        = EV_RESUME;
                  end
               end
            end else begin
               hold_fired_in = 1'b0;
               if ((up_edge || down_edge) &&
                   edge_elapsed >= {16'd0, cfg.edge_lockout_ms}) begin
                  last_edge_time_in     = req.now_ms;
                  last_activity_time_in = req.now_ms;
                  rsp.activity          = 1'b1;
                  rsp.side_event        = req.up_down ? EV_UP : EV_DOWN;
               end
            end
         end

         // Power button: long hold forces off, release after the minimum is a short press
         if (req.ok_down) begin
            last_activity_time_in = req.now_ms;
            rsp.activity          = 1'b1;
            ok_held_in            = 1'b1;
            ok_press_time_in      = ok_press_eff;
            if (ok_elapsed > {16'd0, cfg.power_hold_ms}) begin
               off = PWR_OFF;
            end
         end else begin
            ok_held_in = 1'b0;
            if (ok_held_ff && ok_elapsed > {16'd0, cfg.short_press_min_ms}) begin
               rsp.ok_short = 1'b1;
               if (!req.app_accepts_ok && req.pinned_mode) begin
                  off = PWR_OFF;
               end
            end
         end

         if (off == PWR_ON && batt_elapsed >= {10'd0, cfg.battery_check_period_ms}) begin
            last_batt_time_in = req.now_ms;
            if (!req.charging && req.battery_present &&
                req.battery_pct <= cfg.batt_low_level) begin
               off = PWR_LOW_BATT;
            end
         end

         // Idle timer counts from the latest activity, including this tick's
         if (off == PWR_ON) begin
            idle_gap = req.now_ms - last_activity_time_in;
            if (req.app_wants_tick) begin
               last_activity_time_in = req.now_ms;
               rsp.activity          = 1'b1;
            end else if (cfg.idle_timeout_ms != 27'd0 &&
                         idle_gap > {5'd0, cfg.idle_timeout_ms}) begin
               off = PWR_OFF;
            end
         end
      end

      off_latched_in = off;
      rsp.power_off  = off;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_prev_ff            <= 1'b0;
         down_prev_ff          <= 1'b0;
         hold_fired_ff         <= 1'b0;
         ok_held_ff            <= 1'b0;
         up_press_time_ff      <= '0;
         down_press_time_ff    <= '0;
         last_edge_time_ff     <= '0;
         ok_press_time_ff      <= '0;
         last_activity_time_ff <= '0;
         last_batt_time_ff     <= '0;
         off_latched_ff        <= PWR_ON;
      end else if (step_en) begin
         up_prev_ff            <= up_prev_in;
         down_prev_ff          <= down_prev_in;
         hold_fired_ff         <= hold_fired_in;
         ok_held_ff            <= ok_held_in;
         up_press_time_ff      <= up_press_time_in;
         down_press_time_ff    <= down_press_time_in;
         last_edge_time_ff     <= last_edge_time_in;
         ok_press_time_ff      <= ok_press_time_in;
         last_activity_time_ff <= last_activity_time_in;
         last_batt_time_ff     <= last_batt_time_in;
         off_latched_ff        <= off_latched_in;
      end
   end

endmodule

`default_nettype wire
